FILE: rtl/tri2d_pkg.sv
// Package for the 2D three-anchor trilateration block: widths, types, register codes.
package tri2d_pkg;

  // field and datapath widths
  localparam int RANGE_W   = 16;
  localparam int COORD_W   = 16;
  localparam int SQ_W      = 32;                // any 16-bit square
  localparam int DIFF_W    = 18;                // 2*(coordinate difference)
  localparam int LIN_W     = 34;                // right-hand sides c and f
  localparam int CROSS_W   = 36;                // a*e, b*d
  localparam int DET_W     = 37;                // determinant
  localparam int PROD_W    = 52;                // c*e, b*f, a*f, c*d
  localparam int NUM_W     = 53;                // Cramer numerators
  localparam int MAG_W     = 52;                // numerator magnitude
  localparam int DEN_W     = 36;                // determinant magnitude
  localparam int POS_W     = 24;
  localparam int QBITS     = 24;                // quotient bits built by the divider
  localparam int HEAD_W    = MAG_W - QBITS;     // numerator bits above the quotient window
  localparam int MIN_DET_W = 32;

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // output buffer depth
  localparam logic [1:0] SKID_DEPTH = 2'd2;

  // saturation limits
  localparam logic signed [POS_W-1:0] POS_MAX   = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN   = 24'sh800000;
  localparam logic        [QBITS-1:0] NEG_LIMIT = 24'h800000;

  // register indexes
  typedef enum logic [2:0] {
    REG_ANCHOR1_X = 3'd0,
    REG_ANCHOR1_Y = 3'd1,
    REG_ANCHOR2_X = 3'd2,
    REG_ANCHOR2_Y = 3'd3,
    REG_ANCHOR3_X = 3'd4,
    REG_ANCHOR3_Y = 3'd5,
    REG_MIN_DET   = 3'd6
  } reg_idx_t;

  // input word: three ranges
  typedef struct packed {
    logic [RANGE_W-1:0] range1;
    logic [RANGE_W-1:0] range2;
    logic [RANGE_W-1:0] range3;
  } meas_t;

  // output word: position and flag
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    pos_valid;
  } fix_t;

  // anchor layout and threshold
  typedef struct packed {
    logic signed [COORD_W-1:0] anchor1_x;
    logic signed [COORD_W-1:0] anchor1_y;
    logic signed [COORD_W-1:0] anchor2_x;
    logic signed [COORD_W-1:0] anchor2_y;
    logic signed [COORD_W-1:0] anchor3_x;
    logic signed [COORD_W-1:0] anchor3_y;
    logic [MIN_DET_W-1:0]      min_det;
  } cfg_t;

  // front end to divider: magnitudes and signs of both quotients
  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic             neg_x;
    logic             neg_y;
    logic [DEN_W-1:0] den;
    logic             ok;
  } quot_t;

endpackage

FILE: rtl/tri2d_cfg.sv
// Configuration registers of the trilateration block behind an APB-style port.
module tri2d_cfg import tri2d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.anchor1_x <= 16'sd0;
      cfg.anchor1_y <= 16'sd0;
      cfg.anchor2_x <= 16'sd4000;
      cfg.anchor2_y <= 16'sd0;
      cfg.anchor3_x <= 16'sd0;
      cfg.anchor3_y <= 16'sd3000;
      cfg.min_det   <= 32'd1;
    end else if (wr) begin
      unique case (idx)
        REG_ANCHOR1_X: cfg.anchor1_x <= pwdata[COORD_W-1:0];
        REG_ANCHOR1_Y: cfg.anchor1_y <= pwdata[COORD_W-1:0];
        REG_ANCHOR2_X: cfg.anchor2_x <= pwdata[COORD_W-1:0];
        REG_ANCHOR2_Y: cfg.anchor2_y <= pwdata[COORD_W-1:0];
        REG_ANCHOR3_X: cfg.anchor3_x <= pwdata[COORD_W-1:0];
        REG_ANCHOR3_Y: cfg.anchor3_y <= pwdata[COORD_W-1:0];
        REG_MIN_DET:   cfg.min_det   <= pwdata[MIN_DET_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_ANCHOR1_X: prdata = {16'b0, cfg.anchor1_x};
      REG_ANCHOR1_Y: prdata = {16'b0, cfg.anchor1_y};
      REG_ANCHOR2_X: prdata = {16'b0, cfg.anchor2_x};
      REG_ANCHOR2_Y: prdata = {16'b0, cfg.anchor2_y};
      REG_ANCHOR3_X: prdata = {16'b0, cfg.anchor3_x};
      REG_ANCHOR3_Y: prdata = {16'b0, cfg.anchor3_y};
      REG_MIN_DET:   prdata = cfg.min_det;
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/tri2d_front.sv
// Five-stage front end: squares, linear system, determinant, Cramer numerators, signs.
module tri2d_front import tri2d_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  meas_valid,
  input  meas_t meas,
  input  cfg_t  cfg,
  output logic  quot_valid,
  output quot_t quot
);

  logic [4:0] v;

  // stage 1: squares and coefficient differences
  logic        [SQ_W-1:0]   s1_r1sq, s1_r2sq, s1_r3sq;
  logic signed [SQ_W-1:0]   s1_x1sq, s1_y1sq, s1_x2sq, s1_y2sq, s1_x3sq, s1_y3sq;
  logic signed [DIFF_W-1:0] s1_a, s1_b, s1_d, s1_e;
  // stage 2: right-hand sides and determinant cross terms
  logic signed [LIN_W-1:0]   s2_c, s2_f;
  logic signed [CROSS_W-1:0] s2_ae, s2_bd;
  logic signed [DIFF_W-1:0]  s2_a, s2_b, s2_d, s2_e;
  // stage 3: determinant and numerator products
  logic signed [DET_W-1:0]  s3_det;
  logic signed [PROD_W-1:0] s3_ce, s3_bf, s3_af, s3_cd;
  // stage 4: numerators
  logic signed [DET_W-1:0] s4_det;
  logic signed [NUM_W-1:0] s4_nx, s4_ny;

  logic signed [LIN_W-1:0] base, c_next, f_next;
  logic signed [NUM_W-1:0] abs_x, abs_y;
  logic signed [DET_W-1:0] abs_det;
  quot_t                   quot_next;

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[3:0], meas_valid};
    end
  end

  assign quot_valid = v[4];

  // circle differences against anchor 1
  always_comb begin
    base   = $signed({2'b00, s1_r1sq}) - LIN_W'(s1_x1sq) - LIN_W'(s1_y1sq);
    c_next = base - $signed({2'b00, s1_r2sq}) + LIN_W'(s1_x2sq) + LIN_W'(s1_y2sq);
    f_next = base - $signed({2'b00, s1_r3sq}) + LIN_W'(s1_x3sq) + LIN_W'(s1_y3sq);
  end

  // magnitudes, quotient signs and determinant check
  always_comb begin
    abs_x   = s4_nx[NUM_W-1] ? -s4_nx : s4_nx;
    abs_y   = s4_ny[NUM_W-1] ? -s4_ny : s4_ny;
    abs_det = s4_det[DET_W-1] ? -s4_det : s4_det;
    quot_next.mag_x = abs_x[MAG_W-1:0];
    quot_next.mag_y = abs_y[MAG_W-1:0];
    quot_next.neg_x = s4_nx[NUM_W-1] ^ s4_det[DET_W-1];
    quot_next.neg_y = s4_ny[NUM_W-1] ^ s4_det[DET_W-1];
    quot_next.den   = abs_det[DEN_W-1:0];
    quot_next.ok    = (s4_det != '0) && (abs_det[DEN_W-1:0] >= DEN_W'(cfg.min_det));
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r1sq <= meas.range1 * meas.range1;
      s1_r2sq <= meas.range2 * meas.range2;
      s1_r3sq <= meas.range3 * meas.range3;
      s1_x1sq <= cfg.anchor1_x * cfg.anchor1_x;
      s1_y1sq <= cfg.anchor1_y * cfg.anchor1_y;
      s1_x2sq <= cfg.anchor2_x * cfg.anchor2_x;
      s1_y2sq <= cfg.anchor2_y * cfg.anchor2_y;
      s1_x3sq <= cfg.anchor3_x * cfg.anchor3_x;
      s1_y3sq <= cfg.anchor3_y * cfg.anchor3_y;
      s1_a    <= (DIFF_W'(cfg.anchor2_x) - DIFF_W'(cfg.anchor1_x)) <<< 1;
      s1_b    <= (DIFF_W'(cfg.anchor2_y) - DIFF_W'(cfg.anchor1_y)) <<< 1;
      s1_d    <= (DIFF_W'(cfg.anchor3_x) - DIFF_W'(cfg.anchor1_x)) <<< 1;
      s1_e    <= (DIFF_W'(cfg.anchor3_y) - DIFF_W'(cfg.anchor1_y)) <<< 1;

      s2_c  <= c_next;
      s2_f  <= f_next;
      s2_ae <= s1_a * s1_e;
      s2_bd <= s1_b * s1_d;
      s2_a  <= s1_a;
      s2_b  <= s1_b;
      s2_d  <= s1_d;
      s2_e  <= s1_e;

      s3_det <= DET_W'(s2_ae) - DET_W'(s2_bd);
      s3_ce  <= s2_c * s2_e;
      s3_bf  <= s2_b * s2_f;
      s3_af  <= s2_a * s2_f;
      s3_cd  <= s2_c * s2_d;

      s4_det <= s3_det;
      s4_nx  <= NUM_W'(s3_ce) - NUM_W'(s3_bf);
      s4_ny  <= NUM_W'(s3_af) - NUM_W'(s3_cd);

      quot <= quot_next;
    end
  end

endmodule

FILE: rtl/tri2d_div.sv
// Pipelined restoring divider for both axes, saturation, and a two-word output buffer.
module tri2d_div import tri2d_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  quot_valid,
  input  quot_t quot,
  output logic  adv,
  output logic  fix_valid,
  input  logic  fix_ready,
  output fix_t  fix
);

  // one lane: partial remainder, numerator bits still to shift in, quotient so far
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QBITS-1:0] low;
    logic [QBITS-1:0] q;
  } lane_t;

  typedef struct packed {
    lane_t [1:0]      lane;
    logic  [1:0]      neg;
    logic  [1:0]      ovf;
    logic  [DEN_W-1:0] den;
    logic             ok;
  } dstage_t;

  // one quotient bit: shift in a numerator bit, subtract the divisor if it fits
  function automatic lane_t lane_step(lane_t s, logic [DEN_W-1:0] den);
    lane_t        r;
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    t    = {s.rem, s.low[QBITS-1]};
    diff = t - {1'b0, den};
    r.low = {s.low[QBITS-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      r.rem = diff[DEN_W-1:0];
      r.q   = {s.q[QBITS-2:0], 1'b1};
    end else begin
      r.rem = t[DEN_W-1:0];
      r.q   = {s.q[QBITS-2:0], 1'b0};
    end
    return r;
  endfunction

  // signed result with saturation; zero when the layout is degenerate
  function automatic logic signed [POS_W-1:0] sat(logic [QBITS-1:0] q, logic neg,
                                                   logic ovf, logic ok);
    logic signed [POS_W-1:0] p;
    priority if (!ok) begin
      p = '0;
    end else if (ovf) begin
      p = neg ? POS_MIN : POS_MAX;
    end else if (neg) begin
      p = (q > NEG_LIMIT) ? POS_MIN : -q;
    end else begin
      p = q[QBITS-1] ? POS_MAX : q;
    end
    return p;
  endfunction

  dstage_t        stg [QBITS+1];
  logic [QBITS:0] v;
  dstage_t        init;
  fix_t           done;

  fix_t       ent [2];
  logic       wptr, rptr;
  logic [1:0] cnt;
  logic       push, pop;

  // stage 0: split numerators, flag quotients that cannot fit in the window
  always_comb begin
    init.lane[0].rem = DEN_W'(quot.mag_x[MAG_W-1:QBITS]);
    init.lane[0].low = quot.mag_x[QBITS-1:0];
    init.lane[0].q   = '0;
    init.lane[1].rem = DEN_W'(quot.mag_y[MAG_W-1:QBITS]);
    init.lane[1].low = quot.mag_y[QBITS-1:0];
    init.lane[1].q   = '0;
    init.neg = {quot.neg_y, quot.neg_x};
    init.ovf[0] = DEN_W'(quot.mag_x[MAG_W-1:QBITS]) >= quot.den;
    init.ovf[1] = DEN_W'(quot.mag_y[MAG_W-1:QBITS]) >= quot.den;
    init.den = quot.den;
    init.ok  = quot.ok;
  end

  // whole pipeline moves while the output buffer has room
  assign adv  = (cnt != SKID_DEPTH);
  assign push = adv & v[QBITS];
  assign pop  = fix_valid & fix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[QBITS-1:0], quot_valid};
    end
  end

  // divider stages: stage 0 takes the split numerators, each later stage builds one quotient bit
  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0] <= init;
      for (int k = 1; k <= QBITS; k++) begin
        stg[k].lane[0] <= lane_step(stg[k-1].lane[0], stg[k-1].den);
        stg[k].lane[1] <= lane_step(stg[k-1].lane[1], stg[k-1].den);
        stg[k].neg     <= stg[k-1].neg;
        stg[k].ovf     <= stg[k-1].ovf;
        stg[k].den     <= stg[k-1].den;
        stg[k].ok      <= stg[k-1].ok;
      end
    end
  end

  // final word
  always_comb begin
    done.pos_x     = sat(stg[QBITS].lane[0].q, stg[QBITS].neg[0], stg[QBITS].ovf[0],
                         stg[QBITS].ok);
    done.pos_y     = sat(stg[QBITS].lane[1].q, stg[QBITS].neg[1], stg[QBITS].ovf[1],
                         stg[QBITS].ok);
    done.pos_valid = stg[QBITS].ok;
  end

  // output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // output buffer storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= done;
    end
  end

  assign fix_valid = (cnt != 2'd0);
  assign fix       = ent[rptr];

endmodule

FILE: rtl/trilateration_2d_three_anchor_unit.sv
// Top level of the 2D three-anchor trilateration block.
// Takes a word of three ranges (mm) to configured anchors and returns one position word
// per input: x and y in mm, truncated toward zero and saturated to 24 bits, plus a valid
// flag that is low (position zero) when |det| of the anchor layout is below min_det or
// zero. A new word is taken every cycle while the output buffer has room. Each word
// passes five front-end stages (squares, linear system, determinant, numerators,
// signs), a 25-stage restoring divider (a split stage, then one quotient bit per stage
// for both axes in parallel) and a two-word output buffer that lets the pipeline keep
// taking input while a result waits; input stalls only once the buffer is full.
// Anchors and min_det are written through the APB-style port at byte address 4*index;
// the user must do so only while no word is in flight; the block does not enforce it.
module trilateration_2d_three_anchor_unit import tri2d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // ranges in
  input  logic              meas_valid,
  output logic              meas_ready,
  input  meas_t             meas,
  // position out
  output logic              fix_valid,
  input  logic              fix_ready,
  output fix_t              fix
);

  cfg_t  cfg;
  logic  adv;
  logic  quot_valid;
  quot_t quot;

  assign meas_ready = adv;

  // register bank
  tri2d_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // linear system and Cramer numerators
  tri2d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .meas_valid (meas_valid),
    .meas       (meas),
    .cfg        (cfg),
    .quot_valid (quot_valid),
    .quot       (quot)
  );

  // division, saturation, output buffer
  tri2d_div u_div (
    .clk        (clk),
    .rst        (rst),
    .quot_valid (quot_valid),
    .quot       (quot),
    .adv        (adv),
    .fix_valid  (fix_valid),
    .fix_ready  (fix_ready),
    .fix        (fix)
  );

endmodule
